### sv/prq_pkg.sv
// Package for the priority ring queue: sizes, request and result types, helpers.
package prq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int PRIO_WIDTH    = 4;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = PRIO_WIDTH + PAYLOAD_WIDTH;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WB,
        S_FIN
    } t_state;

    typedef struct packed {
        t_req                     req_type;
        logic [PAYLOAD_WIDTH-1:0] payload_in;
        logic [PRIO_WIDTH-1:0]    prio_in;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic [PAYLOAD_WIDTH-1:0] payload_out;
        logic [CNT_W-1:0]         occupancy;
    } t_out_item;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

### sv/prq_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/priority_ring_queue.sv
// Priority ring queue top level: request sequencer around one entry RAM.
//
// Requests arrive on i_in_valid / o_in_ready / i_in_data and results leave on
// o_out_valid / i_out_ready / o_out_data, one result per request.
// A push stores payload and priority at the tail; a full queue returns
// STAT_FULL. A pop scans the live entries from head to tail, one RAM read per
// cycle, returns the first entry with the highest priority, moves the head
// entry into the freed slot and advances the head; an empty queue returns
// STAT_EMPTY. occupancy is the entry count after the request.
// A push or an empty pop goes from S_IDLE straight to S_FIN, which registers
// the result; a pop of a non-empty queue first passes through S_SCAN, which
// walks the live entries through the entry RAM's single read port, then S_WB.
// One request is handled at a time; o_in_ready is high only while idle, so a
// new request is taken only after S_FIN has registered the previous result.
// A new request can be accepted while the previous result waits in the output
// register; its result is held back until that one is taken.
// Reset empties the queue (head, tail, count cleared) and drops any result;
// RAM contents are not cleared and are only read after being written.
module priority_ring_queue
    import prq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_issued, n_issued;
    logic [PTR_W-1:0]   r_scan_ptr, n_scan_ptr;
    logic               r_rd_vld, n_rd_vld;
    logic [PTR_W-1:0]   r_rd_addr, n_rd_addr;
    logic               r_first, n_first;
    logic               r_out_valid, n_out_valid;
    t_in_item           r_req, n_req;
    t_out_item          r_out, n_out;
    logic [PTR_W-1:0]   r_best_idx, n_best_idx;
    logic [ENTRY_W-1:0] r_best, n_best;
    logic [ENTRY_W-1:0] r_head_entry, n_head_entry;

    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               out_free;

    prq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_scan_ptr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_issued     = r_issued;
        n_scan_ptr   = r_scan_ptr;
        n_rd_vld     = 1'b0;
        n_rd_addr    = r_scan_ptr;
        n_first      = r_first;
        n_req        = r_req;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_best_idx   = r_best_idx;
        n_best       = r_best;
        n_head_entry = r_head_entry;
        ram_we       = 1'b0;
        ram_waddr    = r_best_idx;
        ram_wdata    = r_head_entry;
        o_in_ready   = 1'b0;

        // scan result compare, one entry per cycle
        if (r_rd_vld) begin
            if (r_first) begin
                n_first      = 1'b0;
                n_head_entry = ram_rdata;
                n_best       = ram_rdata;
                n_best_idx   = r_rd_addr;
            end else if (ram_rdata[ENTRY_W-1 -: PRIO_WIDTH] > r_best[ENTRY_W-1 -: PRIO_WIDTH]) begin
                n_best       = ram_rdata;
                n_best_idx   = r_rd_addr;
            end
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req = i_in_data;
                    if (i_in_data.req_type == REQ_POP && r_count != '0) begin
                        n_state    = S_SCAN;
                        n_scan_ptr = r_head;
                        n_issued   = '0;
                        n_first    = 1'b1;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (r_issued != r_count) begin
                    n_rd_vld   = 1'b1;
                    n_scan_ptr = next_slot(r_scan_ptr);
                    n_issued   = r_issued + CNT_W'(1);
                end else if (!r_rd_vld) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                ram_we    = 1'b1;
                ram_waddr = r_best_idx;
                ram_wdata = r_head_entry;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state           = S_IDLE;
                    n_out_valid       = 1'b1;
                    n_out.status      = STAT_OK;
                    n_out.payload_out = '0;
                    n_out.occupancy   = r_count;
                    if (r_req.req_type == REQ_PUSH) begin
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_out.status = STAT_FULL;
                        end else begin
                            ram_we          = 1'b1;
                            ram_waddr       = r_tail;
                            ram_wdata       = {r_req.prio_in, r_req.payload_in};
                            n_tail          = next_slot(r_tail);
                            n_count         = r_count + CNT_W'(1);
                            n_out.occupancy = r_count + CNT_W'(1);
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_out.status = STAT_EMPTY;
                        end else begin
                            n_out.payload_out = r_best[PAYLOAD_WIDTH-1:0];
                            n_head            = next_slot(r_head);
                            n_count           = r_count - CNT_W'(1);
                            n_out.occupancy   = r_count - CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_issued    <= '0;
            r_rd_vld    <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_issued    <= n_issued;
            r_rd_vld    <= n_rd_vld;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_ptr   <= n_scan_ptr;
        r_rd_addr    <= n_rd_addr;
        r_req        <= n_req;
        r_out        <= n_out;
        r_best_idx   <= n_best_idx;
        r_best       <= n_best;
        r_head_entry <= n_head_entry;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_ptrs_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_W'(QUEUE_DEPTH)) |-> r_head == r_tail)
        else $error("head and tail disagree with entry count");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_count != '0)
        else $error("scan started on empty queue");

    a_wb_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WB |-> !r_rd_vld && !r_first && r_issued == r_count)
        else $error("write-back before scan finished");

    a_write_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_WB || r_state == S_FIN))
        else $error("RAM write outside write-back or finish");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !out_free) |=> r_state == S_FIN && $stable(r_count))
        else $error("request finished while result register busy");

endmodule
